@@ sv/sircd_pkg.sv @@
// Package for the IR frame decoder: constants, frame status type and pulse match helper.
`default_nettype none
package sircd_pkg;

  localparam int MAX_CODE_BITS   = 19;
  localparam int MAX_FRAME_ITEMS = 64;

  localparam int MARK_W  = 15;
  localparam int COUNT_W = 7;
  localparam int TIME_W  = 16;
  localparam int TOL_W   = 10;
  localparam int CODE_W  = 19;
  localparam int BITS_W  = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [MARK_W-1:0] HDR_MARK_US  = MARK_W'(2400);
  localparam logic [MARK_W-1:0] ONE_MARK_US  = MARK_W'(1200);
  localparam logic [MARK_W-1:0] ZERO_MARK_US = MARK_W'(600);
  localparam logic [MARK_W-1:0] SPACE_US     = MARK_W'(600);
  localparam logic [MARK_W-1:0] END_SPACE_US = MARK_W'(15000);

  localparam logic [COUNT_W-1:0] MIN_ITEMS   = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] MID_ITEMS   = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] LONG_ITEMS  = COUNT_W'(20);
  localparam logic [COUNT_W-1:0] MAX_ITEMS   = COUNT_W'(MAX_FRAME_ITEMS);
  localparam logic [COUNT_W-1:0] INDEX_SAT   = {COUNT_W{1'b1}};

  localparam int BITS_LONG_I  = (MAX_CODE_BITS < 19) ? MAX_CODE_BITS : 19;
  localparam int BITS_MID_I   = (MAX_CODE_BITS < 14) ? MAX_CODE_BITS : 14;
  localparam int BITS_SHORT_I = (MAX_CODE_BITS < 11) ? MAX_CODE_BITS : 11;
  localparam logic [BITS_W-1:0] BITS_LONG  = BITS_W'(BITS_LONG_I);
  localparam logic [BITS_W-1:0] BITS_MID   = BITS_W'(BITS_MID_I);
  localparam logic [BITS_W-1:0] BITS_SHORT = BITS_W'(BITS_SHORT_I);

  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(200);
  localparam logic [TIME_W-1:0] HOLD_RESET = TIME_W'(100);

  localparam logic REG_TOL  = 1'b0;
  localparam logic REG_HOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_DECODING = 3'b001,
    ST_DONE     = 3'b010,
    ST_FAILED   = 3'b100
  } frame_status_t;

  function automatic logic near_value(input logic [MARK_W-1:0] v,
                                      input logic [MARK_W-1:0] nominal,
                                      input logic [TOL_W-1:0]  tol);
    logic [MARK_W-1:0] d;
    d = (v > nominal) ? (v - nominal) : (nominal - v);
    return d <= MARK_W'(tol);
  endfunction

endpackage
`default_nettype wire

@@ sv/sirc_ir_frame_decoder.sv @@
// Top level of the IR frame decoder: input stage, pulse classifier, frame state and result register.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | mark_us, space_us, frame_items, last_item, time_ms
//  out     | out_valid/out_ready| code_valid, code, is_new
//  config  | APB psel/penable   | match_tolerance_us @0x0, repeat_hold_ms @0x4
//
// One item per cycle unless a stalled result holds a last item: each item waits in the input
// register, is classified and folded into the frame state; a last item loads the result register.
// A last item's result is presented from the result register once the item leaves the input register.
// rst_n is synchronous; it clears control state and restores register defaults.
// A stalled result holds a last item in the input register, which then blocks the
// input; other items keep flowing.
`default_nettype none
module sirc_ir_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [14:0] in_mark_us,
  input  wire logic [14:0] in_space_us,
  input  wire logic [6:0]  in_frame_items,
  input  wire logic        in_last_item,
  input  wire logic [15:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_code_valid,
  output logic [18:0]      out_code,
  output logic             out_is_new,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int MW = sircd_pkg::MARK_W;
  localparam int CW = sircd_pkg::CODE_W;
  localparam int TW = sircd_pkg::TIME_W;
  localparam int NW = sircd_pkg::COUNT_W;
  localparam int BW = sircd_pkg::BITS_W;

  // configuration
  logic [sircd_pkg::TOL_W-1:0] tol_r;
  logic [TW-1:0]               hold_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= sircd_pkg::TOL_RESET;
      hold_r <= sircd_pkg::HOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        sircd_pkg::REG_TOL:  tol_r  <= pwdata[sircd_pkg::TOL_W-1:0];
        sircd_pkg::REG_HOLD: hold_r <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sircd_pkg::REG_TOL:  prdata = {{(32-sircd_pkg::TOL_W){1'b0}}, tol_r};
      sircd_pkg::REG_HOLD: prdata = {{(32-TW){1'b0}}, hold_r};
      default:             prdata = '0;
    endcase
  end

  // input stage
  logic          s1_valid_r;
  logic [MW-1:0] s1_mark_r;
  logic [MW-1:0] s1_space_r;
  logic [NW-1:0] s1_count_r;
  logic          s1_last_r;
  logic [TW-1:0] s1_time_r;
  logic          out_free;
  logic          s1_go;

  logic          out_valid_r;
  logic          out_code_valid_r;
  logic [CW-1:0] out_code_r;
  logic          out_is_new_r;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mark_r  <= in_mark_us;
      s1_space_r <= in_space_us;
      s1_count_r <= in_frame_items;
      s1_last_r  <= in_last_item;
      s1_time_r  <= in_time_ms;
    end
  end

  // frame state
  logic [NW-1:0]            idx_r, idx_nxt;
  logic [BW-1:0]            bits_r, bits_nxt;
  logic [BW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            acc_r, acc_nxt;
  sircd_pkg::frame_status_t st_r, st_nxt;
  logic [CW-1:0]            prev_code_r, prev_code_nxt;
  logic [TW-1:0]            prev_time_r, prev_time_nxt;

  logic          is_hdr, is_one, is_zero, is_end, count_bad;
  logic [BW-1:0] hdr_bits;
  logic          res_valid;
  logic [CW-1:0] res_code;
  logic          res_new;
  logic [TW-1:0] gap;

  always_comb begin
    is_hdr  = sircd_pkg::near_value(s1_mark_r, sircd_pkg::HDR_MARK_US, tol_r) &&
              sircd_pkg::near_value(s1_space_r, sircd_pkg::SPACE_US, tol_r);
    is_one  = sircd_pkg::near_value(s1_mark_r, sircd_pkg::ONE_MARK_US, tol_r) &&
              sircd_pkg::near_value(s1_space_r, sircd_pkg::SPACE_US, tol_r);
    is_zero = sircd_pkg::near_value(s1_mark_r, sircd_pkg::ZERO_MARK_US, tol_r) &&
              sircd_pkg::near_value(s1_space_r, sircd_pkg::SPACE_US, tol_r);
    is_end  = s1_space_r > sircd_pkg::END_SPACE_US;
    count_bad = (s1_count_r < sircd_pkg::MIN_ITEMS) || (s1_count_r > sircd_pkg::MAX_ITEMS);
    if (s1_count_r >= sircd_pkg::LONG_ITEMS) begin
      hdr_bits = sircd_pkg::BITS_LONG;
    end else if (s1_count_r >= sircd_pkg::MID_ITEMS) begin
      hdr_bits = sircd_pkg::BITS_MID;
    end else begin
      hdr_bits = sircd_pkg::BITS_SHORT;
    end

    idx_nxt  = idx_r;
    bits_nxt = bits_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    st_nxt   = st_r;

    if (idx_r == '0) begin
      if (count_bad || !is_hdr) begin
        st_nxt = sircd_pkg::ST_FAILED;
      end else begin
        bits_nxt = hdr_bits;
        pos_nxt  = '0;
        acc_nxt  = '0;
        st_nxt   = sircd_pkg::ST_DECODING;
      end
    end else if (st_r == sircd_pkg::ST_DECODING) begin
      if (is_one || is_zero) begin
        if (is_one && (pos_r < BW'(CW))) begin
          acc_nxt = acc_r | (CW'(1) << pos_r);
        end
        pos_nxt = pos_r + BW'(1);
        if (bits_r != '0) begin
          bits_nxt = bits_r - BW'(1);
        end
        if (bits_nxt == '0) begin
          st_nxt = sircd_pkg::ST_DONE;
        end
      end else if (is_end) begin
        st_nxt = sircd_pkg::ST_DONE;
      end else begin
        st_nxt = sircd_pkg::ST_FAILED;
      end
    end
    if (idx_r != sircd_pkg::INDEX_SAT) begin
      idx_nxt = idx_r + NW'(1);
    end

    res_valid = (st_nxt == sircd_pkg::ST_DONE);
    res_code  = res_valid ? acc_nxt : '0;
    gap       = s1_time_r - prev_time_r;
    res_new   = res_valid && ((res_code != prev_code_r) || (gap > hold_r));

    prev_code_nxt = prev_code_r;
    prev_time_nxt = prev_time_r;
    if (s1_last_r) begin
      if (res_valid) begin
        prev_code_nxt = res_code;
        prev_time_nxt = s1_time_r;
      end
      idx_nxt  = '0;
      bits_nxt = '0;
      pos_nxt  = '0;
      acc_nxt  = '0;
      st_nxt   = sircd_pkg::ST_DECODING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      bits_r      <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      st_r        <= sircd_pkg::ST_DECODING;
      prev_code_r <= '0;
      prev_time_r <= '0;
    end else if (s1_go) begin
      idx_r       <= idx_nxt;
      bits_r      <= bits_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      st_r        <= st_nxt;
      prev_code_r <= prev_code_nxt;
      prev_time_r <= prev_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_last_r) begin
      out_code_valid_r <= res_valid;
      out_code_r       <= res_code;
      out_is_new_r     <= res_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_valid = out_code_valid_r;
  assign out_code       = out_code_r;
  assign out_is_new     = out_is_new_r;

  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_code_valid_r) |-> (out_code_r == '0 && !out_is_new_r))
    else $error("invalid result carries a code or new flag");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (idx_r == '0 && st_r == sircd_pkg::ST_DECODING))
    else $error("frame state not cleared after last item");

  a_bits_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0 && st_r == sircd_pkg::ST_DECODING) |-> (bits_r != '0))
    else $error("decoding with no data bits expected");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_ready) |=> (s1_valid_r && s1_last_r))
    else $error("last item dropped while result stalled");

endmodule
`default_nettype wire

@@ tb/sv/sirc_ir_frame_checker.sv @@
// Checker for the IR frame decoder: watches both channels and the APB port, predicts and compares results.
`timescale 1ns / 100ps
`default_nettype none
module sirc_ir_frame_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [14:0]                 in_mark_us,
  input  wire logic [14:0]                 in_space_us,
  input  wire logic [6:0]                  in_frame_items,
  input  wire logic                        in_last_item,
  input  wire logic [15:0]                 in_time_ms,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic                        out_code_valid,
  input  wire logic [18:0]                 out_code,
  input  wire logic                        out_is_new,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sircd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  input  wire logic                        pready,
  output int                               fail_count,
  output int                               pending
);

  localparam int unsigned HEADER_MARK = 2400;
  localparam int unsigned ONE_MARK    = 1200;
  localparam int unsigned ZERO_MARK   = 600;
  localparam int unsigned GAP_NOMINAL = 600;
  localparam int unsigned END_GAP     = 15000;

  localparam logic [sircd_pkg::ADDR_W-1:0] ADDR_TOL  = {sircd_pkg::REG_TOL, 2'b00};
  localparam logic [sircd_pkg::ADDR_W-1:0] ADDR_HOLD = {sircd_pkg::REG_HOLD, 2'b00};

  typedef struct packed {
    logic                         code_valid;
    logic [sircd_pkg::CODE_W-1:0] code;
    logic                         is_new;
  } ir_result_t;

  ir_result_t                    code_q[$];
  logic [sircd_pkg::TOL_W-1:0]   tol_cfg;
  logic [sircd_pkg::TIME_W-1:0]  hold_cfg;
  logic [sircd_pkg::COUNT_W-1:0] pair_idx;
  logic [sircd_pkg::BITS_W-1:0]  bits_left;
  logic [sircd_pkg::BITS_W-1:0]  bit_pos;
  logic [sircd_pkg::CODE_W-1:0]  accum;
  logic [sircd_pkg::CODE_W-1:0]  last_code;
  logic [sircd_pkg::TIME_W-1:0]  last_time;
  sircd_pkg::frame_status_t      status;
  int                            fails;

  function automatic bit close_to(logic [sircd_pkg::MARK_W-1:0] v, int unsigned nominal);
    int unsigned diff;
    diff = (v > nominal) ? v - nominal : nominal - v;
    return diff <= tol_cfg;
  endfunction

  function automatic bit pulse_is(logic [sircd_pkg::MARK_W-1:0] mark,
                                  logic [sircd_pkg::MARK_W-1:0] space,
                                  int unsigned mark_nom);
    return close_to(mark, mark_nom) && close_to(space, GAP_NOMINAL);
  endfunction

  function automatic void clear_frame();
    pair_idx  = '0;
    bits_left = '0;
    bit_pos   = '0;
    accum     = '0;
    status    = sircd_pkg::ST_DECODING;
  endfunction

  function automatic void fold_pair(logic [sircd_pkg::MARK_W-1:0] mark,
                                    logic [sircd_pkg::MARK_W-1:0] space,
                                    logic [sircd_pkg::COUNT_W-1:0] cnt, logic is_last,
                                    logic [sircd_pkg::TIME_W-1:0] now);
    ir_result_t                   r;
    logic [sircd_pkg::TIME_W-1:0] gap;
    if (pair_idx == '0) begin
      if (cnt < 12 || cnt > sircd_pkg::MAX_FRAME_ITEMS ||
          !pulse_is(mark, space, HEADER_MARK)) begin
        status = sircd_pkg::ST_FAILED;
      end else begin
        bits_left = (cnt >= 20) ? 5'd19 : (cnt >= 15) ? 5'd14 : 5'd11;
        bit_pos   = '0;
        accum     = '0;
        status    = sircd_pkg::ST_DECODING;
      end
    end else if (status == sircd_pkg::ST_DECODING) begin
      if (pulse_is(mark, space, ONE_MARK)) begin
        // overlapping tolerances resolve to a one
        if (bit_pos < sircd_pkg::CODE_W) accum[bit_pos] = 1'b1;
      end else if (!pulse_is(mark, space, ZERO_MARK)) begin
        status = (space > END_GAP) ? sircd_pkg::ST_DONE : sircd_pkg::ST_FAILED;
      end
      if (status == sircd_pkg::ST_DECODING) begin
        bit_pos++;
        if (bits_left != 0) bits_left--;
        if (bits_left == 0) status = sircd_pkg::ST_DONE;
      end
    end
    if (pair_idx != {sircd_pkg::COUNT_W{1'b1}}) pair_idx++;

    if (is_last) begin
      r.code_valid = (status == sircd_pkg::ST_DONE);
      r.code       = r.code_valid ? accum : '0;
      r.is_new     = 1'b0;
      if (r.code_valid) begin
        gap      = now - last_time;
        r.is_new = (accum != last_code) || (gap > hold_cfg);
        last_code = accum;
        last_time = now;
      end
      code_q.push_back(r);
      clear_frame();
    end
  endfunction

  function automatic void flag(string what, ir_result_t want, ir_result_t got);
    fails++;
    if (fails <= 10)
      $display("%0t: %s: expected valid=%0b code=%05h new=%0b, got valid=%0b code=%05h new=%0b",
               $time, what, want.code_valid, want.code, want.is_new,
               got.code_valid, got.code, got.is_new);
  endfunction

  function automatic void check_result();
    ir_result_t got;
    ir_result_t want;
    got.code_valid = out_code_valid;
    got.code       = out_code;
    got.is_new     = out_is_new;
    if (code_q.size() == 0) begin
      flag("result with nothing outstanding", '0, got);
    end else begin
      want = code_q.pop_front();
      if (got !== want) flag("result mismatch", want, got);
    end
  endfunction

  initial begin
    fails = 0;
    clear_frame();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tol_cfg   = sircd_pkg::TOL_RESET;
      hold_cfg  = sircd_pkg::HOLD_RESET;
      last_code = '0;
      last_time = '0;
      clear_frame();
      code_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_TOL:  tol_cfg  = pwdata[sircd_pkg::TOL_W-1:0];
          ADDR_HOLD: hold_cfg = pwdata[sircd_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        fold_pair(in_mark_us, in_space_us, in_frame_items, in_last_item, in_time_ms);
      if (out_valid && out_ready) check_result();
    end
    fail_count <= fails;
    pending    <= code_q.size();
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_sirc_ir_frame_decoder.sv @@
// Testbench top for the IR frame decoder: reset, register set-up, frame stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_sirc_ir_frame_decoder;

  localparam logic [sircd_pkg::ADDR_W-1:0] ADDR_TOL  = {sircd_pkg::REG_TOL, 2'b00};
  localparam logic [sircd_pkg::ADDR_W-1:0] ADDR_HOLD = {sircd_pkg::REG_HOLD, 2'b00};
  localparam int                PHASE_ITEMS = 155;

  typedef struct {
    logic [14:0] mark;
    logic [14:0] space;
    logic [6:0]  count;
    logic        is_last;
    logic [15:0] stamp;
  } ir_pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [14:0]       in_mark_us = '0;
  logic [14:0]       in_space_us = '0;
  logic [6:0]        in_frame_items = '0;
  logic              in_last_item = 1'b0;
  logic [15:0]       in_time_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic              out_code_valid;
  logic [18:0]       out_code;
  logic              out_is_new;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [sircd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                items_sent = 0;
  int                tol_now = 200;
  int                hold_now = 100;
  logic [15:0]       clock_ms = 16'd2000;
  logic [18:0]       sent_code = '0;

  sirc_ir_frame_decoder dut (.*);
  sirc_ir_frame_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  initial begin
    #5_000_000;
    $display("tb_sirc_ir_frame_decoder: FAIL");
    $finish;
  end

  function automatic ir_pair_t pair(int mark, int space, int cnt, bit is_last, int stamp);
    ir_pair_t p;
    p.mark    = 15'(mark);
    p.space   = 15'(space);
    p.count   = 7'(cnt);
    p.is_last = is_last;
    p.stamp   = 16'(stamp);
    return p;
  endfunction

  function automatic logic [14:0] near(int nominal, int slack, bit at_edge);
    int v;
    if (at_edge) v = $urandom_range(1) ? nominal + slack : nominal - slack;
    else v = nominal + int'($urandom_range(2 * slack)) - slack;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function automatic ir_pair_t junk_pair(logic [6:0] cnt);
    ir_pair_t p;
    p.mark    = 15'($urandom);
    p.space   = 15'($urandom);
    p.count   = cnt;
    p.is_last = 1'b0;
    p.stamp   = clock_ms;
    return p;
  endfunction

  task automatic push_pulse(input ir_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_mark_us     = p.mark;
    in_space_us    = p.space;
    in_frame_items = p.count;
    in_last_item   = p.is_last;
    in_time_ms     = p.stamp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [sircd_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drain outstanding results, then let the pipeline empty
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_frame();
    ir_pair_t    frame[$];
    ir_pair_t    p;
    logic [6:0]  cnt;
    logic [18:0] bits;
    int          n_bits;
    int          pos;
    case ($urandom_range(9))
      0, 1, 2: cnt = 7'($urandom_range(14, 12));
      3, 4:    cnt = 7'($urandom_range(19, 15));
      5, 6:    cnt = 7'($urandom_range(24, 20));
      7:       cnt = 7'($urandom_range(64, 25));
      8:       cnt = 7'($urandom_range(11, 0));
      default: cnt = 7'($urandom_range(127, 65));
    endcase
    n_bits = (cnt >= 20) ? 19 : (cnt >= 15) ? 14 : 11;
    bits = ($urandom_range(9) < 3) ? sent_code : 19'($urandom);
    case ($urandom_range(3))
      0: clock_ms = clock_ms + 16'($urandom_range(hold_now));
      1: clock_ms = clock_ms + 16'(hold_now + $urandom_range(1));
      2: clock_ms = clock_ms + 16'($urandom);
      default: ;
    endcase

    p.count   = cnt;
    p.stamp   = clock_ms;
    p.is_last = 1'b0;
    p.mark    = near(2400, tol_now, $urandom_range(7) == 0);
    p.space   = near(600, tol_now, $urandom_range(7) == 0);
    frame.push_back(p);
    for (int k = 0; k < n_bits; k++) begin
      p.mark  = near(bits[k] ? 1200 : 600, tol_now, $urandom_range(7) == 0);
      p.space = near(600, tol_now, $urandom_range(7) == 0);
      frame.push_back(p);
    end

    pos = $urandom_range(n_bits, 1);
    case ($urandom_range(11))
      0: begin
        // early end, or a space at the end limit, either cut short or followed by ignored pairs
        frame[pos].mark  = 15'($urandom);
        frame[pos].space = ($urandom_range(3) == 0) ? 15'(15000 + $urandom_range(1))
                                                    : 15'($urandom_range(32767, 15001));
        if ($urandom_range(1)) while (frame.size() > pos + 1) void'(frame.pop_back());
      end
      1: begin
        frame[pos].mark  = 15'($urandom);
        frame[pos].space = 15'($urandom_range(15000));
      end
      2: while (frame.size() > pos) void'(frame.pop_back());
      3: repeat ($urandom_range(3, 1)) frame.push_back(junk_pair(cnt));
      4: begin
        if ($urandom_range(1)) frame[0].mark = near(2400, tol_now + 1, 1'b1);
        else frame[0].space = near(600, tol_now + 1, 1'b1);
      end
      5: begin
        if ($urandom_range(1)) frame[pos].mark = near(bits[pos-1] ? 1200 : 600, tol_now + 1, 1'b1);
        else frame[pos].space = near(600, tol_now + 1, 1'b1);
      end
      default: ;
    endcase
    frame[frame.size()-1].is_last = 1'b1;
    foreach (frame[i]) push_pulse(frame[i]);
    sent_code = bits;
  endtask

  task automatic send_noise();
    ir_pair_t p;
    int       n;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      p         = junk_pair(7'($urandom));
      p.stamp   = 16'($urandom);
      p.is_last = (k == n - 1) && ($urandom_range(4) != 0);
      push_pulse(p);
    end
  endtask

  initial begin
    logic [9:0]  t;
    logic [15:0] h;
    int          stop_at;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed frames at reset register values
    push_pulse(pair(2400, 600, 12, 0, 1000));
    push_pulse(pair(1000, 16000, 12, 1, 1000));
    push_pulse(pair(2400, 600, 11, 1, 1010));
    push_pulse(pair(2400, 600, 65, 1, 1020));
    push_pulse(pair(2200, 800, 20, 0, 1030));
    push_pulse(pair(1400, 400, 20, 0, 1030));
    push_pulse(pair(32767, 32767, 20, 1, 1030));
    push_pulse(pair(2601, 600, 12, 1, 1040));
    push_pulse(pair(2400, 600, 15, 0, 1050));
    push_pulse(pair(600, 600, 15, 1, 1050));
    push_pulse(pair(2400, 600, 12, 0, 1060));
    push_pulse(pair(0, 0, 12, 1, 1060));
    push_pulse(pair(2400, 600, 14, 0, 1110));
    for (int k = 0; k < 11; k++) push_pulse(pair((11'h5A5 >> k) & 1 ? 1200 : 600, 600, 14, 0, 1110));
    push_pulse(pair(32767, 15000, 14, 0, 1110));
    push_pulse(pair(0, 0, 14, 1, 1110));
    in_valid = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin t = 10'd0; h = 16'd0; end
        1: begin t = 10'd1000; h = 16'hFFFF; end
        2: begin t = 10'd1023; h = 16'd100; end
        3: begin t = 10'd300; h = 16'd1; end
        4: begin t = 10'($urandom); h = 16'($urandom); end
        5: begin t = 10'd200; h = 16'hFFFE; end
        6: begin t = 10'($urandom_range(600)); h = 16'($urandom_range(2000)); end
        default: begin t = 10'd600; h = 16'd30000; end
      endcase
      settle();
      write_reg(ADDR_TOL, {22'($urandom), t});
      write_reg(ADDR_HOLD, {16'($urandom), h});
      tol_now  = t;
      hold_now = h;
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 81; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 81; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(9) < 8) send_frame();
        else send_noise();
      end
      in_valid = 1'b0;
    end

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_sirc_ir_frame_decoder: PASS");
    end else begin
      $display("tb_sirc_ir_frame_decoder: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
